// ----- design/afds_pkg.sv -----
// Shared types and constants for the answer-frame deframer.
// No dependencies; every other design file but afds_ram imports this package.
`default_nettype none

package afds_pkg;

  // Default buffer depth in bytes.
  localparam int unsigned MAX_FRAME_DEF = 64;
  // Shortest frame that can pass the checks.
  localparam int unsigned MIN_LEN = 8;
  // Bytes around the payload: header (2), length, id, command, table, checksum.
  localparam int unsigned FRAME_OVERHEAD = 7;
  // Offset of the first payload byte in the frame.
  localparam int unsigned PAYLOAD_OFS = 6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_OVERSIZE  = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // an input item is accepted this cycle
    logic fetch;    // read the next payload byte from the frame buffer
    logic advance;  // a payload item was delivered; step to the next one
    logic stream;   // the output holds a payload item
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;  // the byte on the input closes the frame
    logic has_pl;     // the closing frame is ok and carries payload bytes
    logic last_pl;    // the current payload item is the last one
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/afds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module afds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/afds_ctrl.sv -----
// Controller state machine for the deframer: receive, fetch and send phases.
// Depends on afds_pkg.
`default_nettype none

module afds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire afds_pkg::dp_stat_t   stat,
  output afds_pkg::ctrl_cmd_t       cmd
);

  import afds_pkg::*;

  typedef enum logic [3:0] {
    S_RECV    = 4'b0001,
    S_ONE     = 4'b0010,
    S_FETCH   = 4'b0100,
    S_SEND_PL = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_RECV: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && stat.frame_end) begin
          state_nxt = stat.has_pl ? S_FETCH : S_ONE;
        end
      end
      S_ONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_RECV;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_SEND_PL;
      end
      S_SEND_PL: begin
        out_valid  = 1'b1;
        cmd.stream = 1'b1;
        if (out_ready) begin
          if (stat.last_pl) begin
            state_nxt = S_RECV;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_FETCH;
          end
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/afds_dp.sv -----
// Datapath for the deframer: byte counter, header and checksum, frame checks,
// field capture, frame buffer and payload index. Depends on afds_pkg, afds_ram.
`default_nettype none

module afds_dp #(
  parameter int unsigned MAX_FRAME = afds_pkg::MAX_FRAME_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic                 in_frame_end,
  input  wire afds_pkg::ctrl_cmd_t  cmd,
  output afds_pkg::dp_stat_t        stat,
  output logic [2:0]                out_status,
  output logic [7:0]                out_length_byte,
  output logic [7:0]                out_device_id,
  output logic [7:0]                out_command_byte,
  output logic [7:0]                out_table_byte,
  output logic                      out_has_payload,
  output logic [7:0]                out_payload_byte,
  output logic [5:0]                out_payload_index,
  output logic                      out_last_result
);

  import afds_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);
  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam int unsigned LW = (CW > 8) ? CW : 8;
  localparam int unsigned IW = (CW > 6) ? CW : 6;

  logic [15:0]   exp_hdr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [15:0]   hdr_r, hdr_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    len_r, id_r, cmd_byte_r, tab_r;
  status_t       status_r;
  logic [CW-1:0] plen_r;
  logic [CW-1:0] pidx_r;

  logic          full;
  logic [CW-1:0] total;
  logic [15:0]   hdr_new;
  status_t       status_c;
  logic [7:0]    lbm2;
  logic [CW-1:0] avail;
  logic [CW-1:0] plen_c;
  logic [CW-1:0] rd_pos;
  logic [7:0]    ram_rdata;
  logic [IW-1:0] pidx_ext;
  logic          ram_we;
  logic          ok_out;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_hdr_r <= '0;
    end else if (cfg_we) begin
      exp_hdr_r <= cfg_wdata;
    end
  end

  // Frame checks on the closing byte, using state from the earlier bytes.
  always_comb begin
    full    = (count_r == CW'(MAX_FRAME));
    total   = full ? count_r : count_r + CW'(1);
    hdr_new = (count_r < CW'(2)) ? {hdr_r[7:0], in_rx_byte} : hdr_r;
    if (ovf_r || full) begin
      status_c = ST_OVERSIZE;
    end else if (total < CW'(MIN_LEN)) begin
      status_c = ST_SHORT;
    end else if (hdr_new != exp_hdr_r) begin
      status_c = ST_BAD_HDR;
    end else if (sum_r != in_rx_byte) begin
      status_c = ST_BAD_SUM;
    end else begin
      status_c = ST_OK;
    end
    // Payload count is the length byte minus two, capped at the bytes
    // that lie between the table byte and the checksum.
    lbm2   = (len_r < 8'd2) ? 8'd0 : len_r - 8'd2;
    avail  = total - CW'(FRAME_OVERHEAD);
    plen_c = (LW'(lbm2) > LW'(avail)) ? avail : CW'(lbm2);
  end

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    hdr_nxt   = hdr_r;
    ovf_nxt   = ovf_r;
    if (cmd.take) begin
      if (in_frame_end) begin
        count_nxt = '0;
        sum_nxt   = '0;
        hdr_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
        hdr_nxt   = hdr_new;
        if (count_r >= CW'(2)) begin
          sum_nxt = sum_r + in_rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      hdr_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      hdr_r   <= hdr_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Fixed header fields are kept in registers as they pass by.
  always_ff @(posedge clk) begin
    if (cmd.take && !full) begin
      if (count_r == CW'(2)) len_r      <= in_rx_byte;
      if (count_r == CW'(3)) id_r       <= in_rx_byte;
      if (count_r == CW'(4)) cmd_byte_r <= in_rx_byte;
      if (count_r == CW'(5)) tab_r      <= in_rx_byte;
    end
    if (cmd.take && in_frame_end) begin
      status_r <= status_c;
      plen_r   <= plen_c;
      pidx_r   <= '0;
    end else if (cmd.advance) begin
      pidx_r <= pidx_r + CW'(1);
    end
  end

  assign ram_we = cmd.take && !full;
  assign rd_pos = pidx_r + CW'(PAYLOAD_OFS);

  afds_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_buf (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_rx_byte),
    .re      (cmd.fetch),
    .raddr   (rd_pos[AW-1:0]),
    .rdata_r (ram_rdata)
  );

  assign stat.frame_end = in_frame_end;
  assign stat.has_pl    = (status_c == ST_OK) && (plen_c != '0);
  assign stat.last_pl   = (pidx_r + CW'(1) == plen_r);

  // Failed frames report only the status code; all other fields read zero, but out_last_result reads one.
  assign ok_out   = (status_r == ST_OK);
  assign pidx_ext = IW'(pidx_r);

  assign out_status        = status_r;
  assign out_length_byte   = ok_out ? len_r : 8'd0;
  assign out_device_id     = ok_out ? id_r : 8'd0;
  assign out_command_byte  = ok_out ? cmd_byte_r : 8'd0;
  assign out_table_byte    = ok_out ? tab_r : 8'd0;
  assign out_has_payload   = cmd.stream;
  assign out_payload_byte  = cmd.stream ? ram_rdata : 8'd0;
  assign out_payload_index = cmd.stream ? pidx_ext[5:0] : 6'd0;
  assign out_last_result   = cmd.stream ? stat.last_pl : 1'b1;

endmodule

`default_nettype wire

// ----- design/answer_frame_deframer_sum.sv -----
// Top level of the answer-frame deframer with additive checksum.
// Depends on afds_pkg, afds_ctrl, afds_dp (and afds_ram below it).
//
//   Channel  Handshake             Payload
//   in_      in_valid/in_ready     in_rx_byte, in_frame_end
//   out_     out_valid/out_ready   status, length, id, command, table, payload
//   cfg_     cfg_we                cfg_wdata (expected header)
//
// A byte without the frame end flag is taken at once; in_ready stays high while receiving.
// After the closing byte, a failed or empty frame gives one result in the next
// cycle; an ok frame streams payload bytes, each read from the buffer and then
// offered at the output, since the frame buffer has a registered read port.
// While results are pending, in_ready is low; out_ready low holds the result.
// Reset is synchronous and active low; the buffer needs no clearing pass.
`default_nettype none

module answer_frame_deframer_sum #(
  parameter int unsigned MAX_FRAME = afds_pkg::MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_length_byte,
  output logic [7:0]       out_device_id,
  output logic [7:0]       out_command_byte,
  output logic [7:0]       out_table_byte,
  output logic             out_has_payload,
  output logic [7:0]       out_payload_byte,
  output logic [5:0]       out_payload_index,
  output logic             out_last_result
);

  import afds_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  afds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  afds_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_rx_byte        (in_rx_byte),
    .in_frame_end      (in_frame_end),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_status),
    .out_length_byte   (out_length_byte),
    .out_device_id     (out_device_id),
    .out_command_byte  (out_command_byte),
    .out_table_byte    (out_table_byte),
    .out_has_payload   (out_has_payload),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_last_result   (out_last_result)
  );

endmodule

`default_nettype wire

// ----- design/afds_checker.sv -----
// Port-level checks for the answer-frame deframer, bound to the top level.
// Depends on afds_pkg.
`default_nettype none

module afds_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_has_payload,
  input wire logic [7:0] out_payload_byte,
  input wire logic       out_last_result
);

  import afds_pkg::*;

  // Input is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // A failed frame never carries payload.
  a_fail_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_has_payload && out_last_result)
    else $error("failed frame result carries payload or is not last");

  // The final item of a frame returns the block to receiving.
  a_last_then_recv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready && !out_valid)
    else $error("block did not return to receive after the last item");

  // A stalled payload item holds its byte.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte))
    else $error("stalled result changed");

endmodule

bind answer_frame_deframer_sum afds_checker u_afds_checker (.*);

`default_nettype wire
